FILE: rtl/lts_pkg.sv
// Shared constants for the lottery task scheduler.
`default_nettype none

package lts_pkg;

	localparam int MAX_TASKS_DEF = 64;
	localparam int ID_W          = 6;
	localparam int OP_W          = 3;
	localparam int QUANT_W       = 16;
	localparam int SEED_W        = 32;
	localparam int DIV_STEPS     = SEED_W;
	localparam int STEP_W        = $clog2(DIV_STEPS);

	localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
	localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
	localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
	localparam logic [OP_W-1:0] OP_EXIT    = 3'd4;

	localparam logic REG_QUANTUM = 1'b0;
	localparam logic REG_SEED    = 1'b1;

	localparam logic [SEED_W-1:0]  LFSR_TAPS   = 32'h8020_0003;
	localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd10;
	localparam logic [SEED_W-1:0]  SEED_RST    = 32'd1;

	typedef logic [OP_W-1:0] op_t;

endpackage

`default_nettype wire

FILE: rtl/lottery_task_scheduler.sv
// Top level of the lottery task scheduler: ready set, draw sequencer and result register.
`default_nettype none

// One-CPU lottery scheduler with one ticket per task. Load and unblock give no
// result beat. A tick that keeps the running task, and any draw with an empty
// ready set, goes from idle to the done state and shows its result beat once the
// result register is free. A draw (quantum expiry, idle tick, block, exit) has
// a start step that advances the LFSR, a bit-serial remainder of the LFSR value by
// the ready count, then a scan over the slots one slot per cycle that stops at the
// drawn ready slot.
// s_tready is low while an item is in work or its result cannot be stored.
// Only slots 0 to min(MAX_TASKS, 64) - 1 can be marked ready.
module lottery_task_scheduler #(
	parameter int MAX_TASKS = lts_pkg::MAX_TASKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,  // [5:0] task_id
	input  wire logic [lts_pkg::OP_W-1:0]    s_tuser,  // [2:0] op
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [7:0]                       m_tdata,  // [5:0] running_task
	output logic                             m_tuser,  // [0] cpu_idle
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [lts_pkg::SEED_W-1:0]  cfg_data
);
	import lts_pkg::*;

	localparam int NSLOT = (MAX_TASKS < 64) ? MAX_TASKS : 64;
	localparam int IDX_W = $clog2(NSLOT);
	localparam int CNT_W = $clog2(NSLOT + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]         state_q;
	logic [NSLOT-1:0]   mask_q;
	logic [CNT_W-1:0]   total_q;
	logic [IDX_W-1:0]   cur_q;
	logic               cur_valid_q;
	logic [QUANT_W-1:0] tick_q;
	logic [QUANT_W-1:0] quantum_q;
	logic [SEED_W-1:0]  lfsr_q;
	logic [SEED_W-1:0]  div_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W-1:0]   rem_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic [ID_W-1:0]    out_task_q;
	logic               out_idle_q;

	op_t                op;
	logic [ID_W-1:0]    task_id;
	logic               accept;
	logic               id_in_range;
	logic [IDX_W-1:0]   id_idx;
	logic [QUANT_W-1:0] tick_inc;
	logic               remove_cur;
	logic [CNT_W-1:0]   total_after;
	logic [SEED_W-1:0]  lfsr_step;
	logic [CNT_W:0]     rem_try;
	logic [CNT_W:0]     rem_sub;
	logic [CNT_W-1:0]   rem_next;
	logic               out_free;

	assign op          = s_tuser;
	assign task_id     = s_tdata[ID_W-1:0];
	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign id_in_range = ({1'b0, task_id} < 7'(NSLOT));
	assign id_idx      = task_id[IDX_W-1:0];
	assign tick_inc    = tick_q + 16'd1;
	assign remove_cur  = cur_valid_q && mask_q[cur_q];
	assign total_after = remove_cur ? total_q - CNT_W'(1) : total_q;
	assign lfsr_step   = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
	assign rem_try     = {rem_q, div_q[SEED_W-1]};
	assign rem_sub     = rem_try - {1'b0, total_q};
	assign rem_next    = (rem_try >= {1'b0, total_q}) ? rem_sub[CNT_W-1:0] : rem_try[CNT_W-1:0];
	assign out_free    = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_task_q};
	assign m_tuser  = out_idle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= '0;
			total_q     <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			tick_q      <= '0;
			quantum_q   <= QUANTUM_RST;
			lfsr_q      <= SEED_RST;
			div_q       <= '0;
			step_q      <= '0;
			rem_q       <= '0;
			idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_QUANTUM: quantum_q <= cfg_data[QUANT_W-1:0];
					REG_SEED:    lfsr_q <= (cfg_data == '0) ? SEED_RST : cfg_data;
					default:     ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority if (op == OP_LOAD || op == OP_UNBLOCK) begin
							if (id_in_range && !mask_q[id_idx]) begin
								mask_q[id_idx] <= 1'b1;
								total_q        <= total_q + CNT_W'(1);
							end
						end else if (op == OP_TICK || op == OP_BLOCK || op == OP_EXIT) begin
							if (op == OP_TICK && tick_inc != quantum_q && cur_valid_q) begin
								tick_q  <= tick_inc;
								state_q <= ST_DONE;
							end else begin
								tick_q      <= '0;
								cur_valid_q <= 1'b0;
								cur_q       <= '0;
								if (op != OP_TICK && remove_cur) begin
									mask_q[cur_q] <= 1'b0;
									total_q       <= total_after;
								end
								if (op == OP_TICK ? (total_q != '0) : (total_after != '0)) begin
									lfsr_q  <= lfsr_step;
									div_q   <= lfsr_step;
									step_q  <= '0;
									rem_q   <= '0;
									state_q <= ST_DIV;
								end else begin
									state_q <= ST_DONE;
								end
							end
						end else begin
						end
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next;
					div_q  <= div_q << 1;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (mask_q[idx_q] && rem_q == '0) begin
						cur_q       <= idx_q;
						cur_valid_q <= 1'b1;
						state_q     <= ST_DONE;
					end else begin
						if (mask_q[idx_q]) begin
							rem_q <= rem_q - CNT_W'(1);
						end
						if (idx_q == IDX_W'(NSLOT - 1)) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_task_q <= cur_valid_q ? ID_W'(cur_q) : '0;
			out_idle_q <= !cur_valid_q;
		end
	end

`ifndef SYNTH
	a_total_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) == $countones(mask_q))
		else $error("ready count differs from ready set");
	a_running_is_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> mask_q[cur_q])
		else $error("running task not in ready set");
	a_scan_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rem_q < total_q))
		else $error("draw index not below ready count");
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("draw LFSR locked at zero");
`endif

endmodule

`default_nettype wire
